### sv/windowed_overlap_add_assert.svh
// Assertion macros for the windowed overlap-add block.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef WINDOWED_OVERLAP_ADD_ASSERT_SVH
`define WINDOWED_OVERLAP_ADD_ASSERT_SVH

`ifndef SYNTH

`define WOA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("windowed_overlap_add: same-cycle check failed");

`define WOA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("windowed_overlap_add: next-cycle check failed");

`else

`define WOA_ASSERT_IMP(label, ante, cons)

`define WOA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/woa_pkg.sv
package woa_pkg;

	localparam int FRAME_LEN = 1024;
	localparam int IDX_W = $clog2(FRAME_LEN);
	localparam int DATA_W = 32;
	localparam int HOP_W = 11;
	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int WIN_W = 17;
	localparam int HOPX_W = (IDX_W + 1 > HOP_W) ? IDX_W + 1 : HOP_W;
	localparam int PROD_W = DATA_W + WIN_W + 1;
	localparam int RND_SH = 16;
	localparam int SUM_W = DATA_W + 4;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

	localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(256);
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint HAMM_A_Q30 = 64'sd579820585;
	localparam longint HAMM_B_Q30 = 64'sd493921239;

	typedef enum logic [1:0] {
		REG_HOP   = 2'd0,
		REG_COUNT = 2'd1,
		REG_WMODE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [HOP_W-1:0] hop;
		logic [CNT_W-1:0] count;
		logic             wmode;
	} woa_cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic [IDX_W-1:0]         j;
		logic [IDX_W-1:0]         pos;
		logic                     emit;
		logic                     bend;
	} woa_item_t;

	typedef logic [WIN_W-1:0] win_tab_t [FRAME_LEN];

	function automatic longint taylor(input longint unsigned x2, input longint unsigned first,
			input logic odd);
		longint sum;
		longint unsigned mag;
		longint unsigned prod;
		sum = longint'(first);
		mag = first;
		for (int k = 1; k <= 6; k++) begin
			prod = (mag * x2) >> 30;
			case ({odd, 3'(k)})
				4'b0001: mag = prod / 2;
				4'b0010: mag = prod / 12;
				4'b0011: mag = prod / 30;
				4'b0100: mag = prod / 56;
				4'b0101: mag = prod / 90;
				4'b0110: mag = prod / 132;
				4'b1001: mag = prod / 6;
				4'b1010: mag = prod / 20;
				4'b1011: mag = prod / 42;
				4'b1100: mag = prod / 72;
				4'b1101: mag = prod / 110;
				4'b1110: mag = prod / 156;
				default: mag = prod;
			endcase
			if (k % 2 == 1) begin
				sum = sum - longint'(mag);
			end else begin
				sum = sum + longint'(mag);
			end
		end
		return sum;
	endfunction

	function automatic longint cos_turn(input logic [31:0] p);
		logic [1:0] quad;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint c;
		quad = p[31:30];
		r = 64'(p[29:0]);
		x = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		case (quad)
			2'd0: c = taylor(x2, longint'(Q30_ONE), 1'b0);
			2'd1: c = -taylor(x2, x, 1'b1);
			2'd2: c = -taylor(x2, longint'(Q30_ONE), 1'b0);
			default: c = taylor(x2, x, 1'b1);
		endcase
		if (c > Q30_ONE) begin
			c = Q30_ONE;
		end
		if (c < -Q30_ONE) begin
			c = -Q30_ONE;
		end
		return c;
	endfunction

	function automatic win_tab_t build_win(input logic hamming);
		win_tab_t tab;
		longint unsigned ph;
		longint c;
		longint v;
		for (int n = 0; n < FRAME_LEN; n++) begin
			ph = (longint'(n) << 32) / (FRAME_LEN - 1);
			c = cos_turn(ph[31:0]);
			if (hamming) begin
				v = HAMM_A_Q30 * Q30_ONE - HAMM_B_Q30 * c;
			end else begin
				v = (longint'(1) << 59) - (longint'(1) << 29) * c;
			end
			tab[n] = WIN_W'((longint'(v) + (longint'(1) << 43)) >> 44);
		end
		return tab;
	endfunction

	localparam win_tab_t WIN_HANN = build_win(1'b0);
	localparam win_tab_t WIN_HAMM = build_win(1'b1);

endpackage

### sv/woa_ram.sv
module woa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/woa_front.sv
module woa_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  woa_pkg::woa_cfg_t          cfg,
	input  logic                       hold,
	input  logic                       push,
	input  logic signed [31:0]         in_sample,
	output logic                       full,
	output woa_pkg::woa_item_t         head,
	output logic                       head_valid,
	input  logic                       head_pop
);
	import woa_pkg::*;

	logic [IDX_W-1:0]    sample_q;
	logic [CNT_W-1:0]    frame_q;
	logic [IDX_W-1:0]    base_q;
	logic [HOPX_W-1:0]   hop_x;
	logic [CNT_W-1:0]    count_x;
	logic [IDX_W:0]      pos_sum;
	logic [HOPX_W:0]     base_sum;
	logic                last;
	logic                frame_done;
	logic                acc;
	woa_item_t           item;

	woa_item_t           mq_q [MQ_DEPTH];
	logic [MQ_PTR_W-1:0] wr_ptr_q;
	logic [MQ_PTR_W-1:0] rd_ptr_q;
	logic [MQ_PTR_W:0]   cnt_q;

	always_comb begin
		hop_x = HOPX_W'(cfg.hop);
		if (hop_x == '0) begin
			hop_x = HOPX_W'(1);
		end else if (hop_x > HOPX_W'(FRAME_LEN)) begin
			hop_x = HOPX_W'(FRAME_LEN);
		end
		count_x = (cfg.count == '0) ? CNT_W'(1) : cfg.count;

		pos_sum = (IDX_W+1)'(base_q) + (IDX_W+1)'(sample_q);
		if (pos_sum >= (IDX_W+1)'(FRAME_LEN)) begin
			pos_sum = pos_sum - (IDX_W+1)'(FRAME_LEN);
		end
		base_sum = (HOPX_W+1)'(base_q) + (HOPX_W+1)'(hop_x);
		if (base_sum >= (HOPX_W+1)'(FRAME_LEN)) begin
			base_sum = base_sum - (HOPX_W+1)'(FRAME_LEN);
		end

		last = ((CNT_W+1)'(frame_q) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count_x);
		frame_done = (sample_q == IDX_W'(FRAME_LEN - 1));

		item.x = in_sample;
		item.j = sample_q;
		item.pos = pos_sum[IDX_W-1:0];
		item.emit = last || (HOPX_W'(sample_q) < hop_x);
		item.bend = last && frame_done;
	end

	assign full = hold || (cnt_q == (MQ_PTR_W+1)'(MQ_DEPTH));
	assign acc = push && !full;
	assign head = mq_q[rd_ptr_q];
	assign head_valid = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			frame_q <= '0;
			base_q <= '0;
		end else if (acc) begin
			if (frame_done) begin
				sample_q <= '0;
				if (last) begin
					frame_q <= '0;
					base_q <= '0;
				end else begin
					frame_q <= frame_q + CNT_W'(1);
					base_q <= base_sum[IDX_W-1:0];
				end
			end else begin
				sample_q <= sample_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mq_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				wr_ptr_q <= wr_ptr_q + MQ_PTR_W'(1);
			end
			if (head_pop) begin
				rd_ptr_q <= rd_ptr_q + MQ_PTR_W'(1);
			end
			if (acc && !head_pop) begin
				cnt_q <= cnt_q + (MQ_PTR_W+1)'(1);
			end else if (!acc && head_pop) begin
				cnt_q <= cnt_q - (MQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

### sv/woa_back.sv
module woa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_mode,
	input  woa_pkg::woa_item_t  head,
	input  logic                head_valid,
	output logic                head_pop,
	output logic                clr_busy,
	input  logic                pop,
	output logic                empty,
	output logic signed [31:0]  out_sample,
	output logic                block_end
);
	import woa_pkg::*;

	logic                      clr_busy_q;
	logic [IDX_W-1:0]          clr_cnt_q;

	logic                      v_s1;
	logic signed [DATA_W-1:0]  x_s1;
	logic [IDX_W-1:0]          pos_s1;
	logic                      emit_s1;
	logic                      bend_s1;
	logic [WIN_W-1:0]          w_s1;
	logic [DATA_W-1:0]         ram_rdata;
	logic signed [PROD_W-1:0]  prod;

	logic                      v_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [IDX_W-1:0]          pos_s2;
	logic                      emit_s2;
	logic                      bend_s2;
	logic signed [DATA_W-1:0]  acc_s2;

	logic                      wr_v_q;
	logic [IDX_W-1:0]          wr_pos_q;
	logic [DATA_W-1:0]         wr_data_q;

	logic signed [PROD_W-1:0]  rnd_full;
	logic signed [SUM_W-1:0]   sum;
	logic [DATA_W-1:0]         sat;
	logic [DATA_W-1:0]         wdata_s2;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [DATA_W-1:0]         ram_wdata;

	logic [DATA_W-1:0]         oq_data_q [OQ_DEPTH];
	logic                      oq_end_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]       oq_wr_q;
	logic [OQ_PTR_W-1:0]       oq_rd_q;
	logic [OQ_PTR_W:0]         oq_cnt_q;
	logic [OQ_PTR_W+1:0]       oq_need;
	logic                      oq_push;
	logic                      oq_pop;

	assign clr_busy = clr_busy_q;

	assign oq_need = (OQ_PTR_W+2)'(oq_cnt_q) + (OQ_PTR_W+2)'(v_s1) + (OQ_PTR_W+2)'(v_s2);
	assign head_pop = head_valid && !clr_busy_q && (oq_need < (OQ_PTR_W+2)'(OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (clr_cnt_q == IDX_W'(FRAME_LEN - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rnd_full = prod_s2 + PROD_W'(1 << (RND_SH - 1));
		sum = SUM_W'(acc_s2) + SUM_W'($signed(rnd_full[PROD_W-1:RND_SH]));
		if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
			sat = sum[DATA_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		wdata_s2 = emit_s2 ? '0 : sat;

		ram_we = clr_busy_q || v_s2;
		ram_waddr = clr_busy_q ? clr_cnt_q : pos_s2;
		ram_wdata = clr_busy_q ? '0 : wdata_s2;
	end

	woa_ram #(
		.WIDTH(DATA_W),
		.DEPTH(FRAME_LEN)
	) u_ring (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(head_pop),
		.raddr(head.pos),
		.rdata(ram_rdata)
	);

	assign prod = x_s1 * $signed({1'b0, w_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			wr_v_q <= 1'b0;
		end else begin
			v_s1 <= head_pop;
			v_s2 <= v_s1;
			wr_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			x_s1 <= head.x;
			pos_s1 <= head.pos;
			emit_s1 <= head.emit;
			bend_s1 <= head.bend;
			w_s1 <= window_mode ? WIN_HAMM[head.j] : WIN_HANN[head.j];
		end
		prod_s2 <= prod;
		pos_s2 <= pos_s1;
		emit_s2 <= emit_s1;
		bend_s2 <= bend_s1;
		// The two items ahead may hit the same ring entry before the RAM holds their writes.
		if (v_s2 && pos_s2 == pos_s1) begin
			acc_s2 <= wdata_s2;
		end else if (wr_v_q && wr_pos_q == pos_s1) begin
			acc_s2 <= wr_data_q;
		end else begin
			acc_s2 <= ram_rdata;
		end
		wr_pos_q <= pos_s2;
		wr_data_q <= wdata_s2;
	end

	assign oq_push = v_s2 && emit_s2;
	assign oq_pop = pop && !empty;
	assign empty = (oq_cnt_q == '0);
	assign out_sample = oq_data_q[oq_rd_q];
	assign block_end = oq_end_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_data_q[oq_wr_q] <= sat;
			oq_end_q[oq_wr_q] <= bend_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + (OQ_PTR_W+1)'(1);
			end else if (!oq_push && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - (OQ_PTR_W+1)'(1);
			end
		end
	end

endmodule

### sv/windowed_overlap_add.sv
// Throughput: one item per cycle while full is low and the output queue has room, set by
// the single read and write port of the ring RAM.
// Reset: hop_size 256, frame_count 1, window_mode Hann; after reset the ring RAM is
// zeroed one entry per cycle, all 1024 entries, with full held high, before items are taken.
`include "windowed_overlap_add_assert.svh"

module windowed_overlap_add (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [31:0] in_sample,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] out_sample,
	output logic               block_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import woa_pkg::*;

	logic [HOP_W-1:0] hop_q;
	logic [CNT_W-1:0] count_q;
	logic             wmode_q;
	woa_cfg_t         cfg;
	woa_item_t        mid_head;
	logic             mid_valid;
	logic             mid_pop;
	logic             clr_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= HOP_RESET;
			count_q <= COUNT_RESET;
			wmode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HOP:   hop_q <= cfg_data[HOP_W-1:0];
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_WMODE: wmode_q <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	assign cfg.hop = hop_q;
	assign cfg.count = count_q;
	assign cfg.wmode = wmode_q;

	woa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.hold(clr_busy),
		.push(push),
		.in_sample(in_sample),
		.full(full),
		.head(mid_head),
		.head_valid(mid_valid),
		.head_pop(mid_pop)
	);

	woa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.window_mode(cfg.wmode),
		.head(mid_head),
		.head_valid(mid_valid),
		.head_pop(mid_pop),
		.clr_busy(clr_busy),
		.pop(pop),
		.empty(empty),
		.out_sample(out_sample),
		.block_end(block_end)
	);

	`WOA_ASSERT_IMP(a_clear_holds_input, clr_busy, full)
	`WOA_ASSERT_IMP(a_clear_no_result, clr_busy, empty)
	`WOA_ASSERT_IMP(a_pop_only_ready, mid_pop, mid_valid && !clr_busy)
	`WOA_ASSERT_NEXT(a_cfg_wmode, cfg_valid && cfg_ready && cfg_index == REG_WMODE, wmode_q == $past(cfg_data[0]))

endmodule
